@@ rtl/aabb_region_enter_leave_detector_defines.svh @@
// assertion helpers for the enter/leave detector
`ifndef AABB_REGION_ENTER_LEAVE_DETECTOR_DEFINES_SVH
`define AABB_REGION_ENTER_LEAVE_DETECTOR_DEFINES_SVH

// same-cycle implication, checked outside reset
`define AERL_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("aerl assertion failed");

// next-cycle implication, checked outside reset
`define AERL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("aerl assertion failed");

`endif

@@ rtl/aerl_pkg.sv @@
package aerl_pkg;

  localparam int DefaultSlots = 32;
  localparam int QueueDepth   = 4;
  localparam int SlotW        = 5;
  localparam int PosW         = 32;
  localparam int HalfW        = 31;
  localparam int NameW        = 16;
  localparam int CfgIdxW      = 3;

  typedef enum logic [1:0] {
    OP_CENTER = 2'd0,
    OP_SAMPLE = 2'd1,
    OP_TICK   = 2'd2
  } op_e;

  localparam logic [CfgIdxW-1:0] REG_HALF_X = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_HALF_Y = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_HALF_Z = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_FILTER = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_TARGET = 3'd4;

  localparam logic EV_ENTER = 1'b0;
  localparam logic EV_LEAVE = 1'b1;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_SET   = 2'd1,
    CMD_TICK  = 2'd2
  } cmd_e;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_EMIT = 1'b1
  } back_state_e;

  typedef struct packed {
    cmd_e             kind;
    logic [SlotW-1:0] slot;
    logic             vol_ok;
  } cmd_t;

  typedef struct packed {
    logic [HalfW-1:0] half_x;
    logic [HalfW-1:0] half_y;
    logic [HalfW-1:0] half_z;
    logic             filter_en;
    logic [NameW-1:0] target_id;
  } cfg_t;

  // |p - c| <= half, exact on 33 bits
  function automatic logic axis_in(logic signed [PosW-1:0] p, logic signed [PosW-1:0] c,
                                   logic [HalfW-1:0] half);
    logic signed [PosW:0] diff;
    logic [PosW:0]        mag;
    diff = {p[PosW-1], p} - {c[PosW-1], c};
    mag  = diff[PosW] ? (~diff + 1'b1) : diff;
    return mag <= {2'b00, half};
  endfunction

endpackage

@@ rtl/aerl_fifo.sv @@
module aerl_fifo #(
  parameter int Depth = aerl_pkg::QueueDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  aerl_pkg::cmd_t push_data_i,
  input  logic           pop_i,
  output aerl_pkg::cmd_t pop_data_o,
  output logic           full_o,
  output logic           empty_o
);
  import aerl_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o     = (count_q == CntW'(Depth));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ rtl/aerl_front.sv @@
module aerl_front #(
  parameter int Slots = aerl_pkg::DefaultSlots
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  aerl_pkg::cfg_t                      cfg_i,
  input  logic                                in_valid_i,
  input  logic                                queue_full_i,
  input  logic [1:0]                          op_i,
  input  logic                                node_valid_i,
  input  logic [aerl_pkg::SlotW-1:0]          entity_slot_i,
  input  logic [aerl_pkg::NameW-1:0]          name_id_i,
  input  logic signed [aerl_pkg::PosW-1:0]    pos_x_i,
  input  logic signed [aerl_pkg::PosW-1:0]    pos_y_i,
  input  logic signed [aerl_pkg::PosW-1:0]    pos_z_i,
  output logic                                push_o,
  output aerl_pkg::cmd_t                      cmd_o
);
  import aerl_pkg::*;

  logic signed [PosW-1:0] ctr_x_q, ctr_x_d;
  logic signed [PosW-1:0] ctr_y_q, ctr_y_d;
  logic signed [PosW-1:0] ctr_z_q, ctr_z_d;
  logic                   vol_ok_q, vol_ok_d;
  logic                   accept;
  logic                   hit;
  logic                   counts;

  assign accept = in_valid_i && !queue_full_i;

  assign hit = axis_in(pos_x_i, ctr_x_q, cfg_i.half_x) &&
               axis_in(pos_y_i, ctr_y_q, cfg_i.half_y) &&
               axis_in(pos_z_i, ctr_z_q, cfg_i.half_z);

  // sample only matters when volume and entity are live, the slot is in range and the name passes
  assign counts = vol_ok_q && node_valid_i && (int'(entity_slot_i) < Slots) &&
                  (!cfg_i.filter_en || (name_id_i == cfg_i.target_id));

  always_comb begin
    ctr_x_d      = ctr_x_q;
    ctr_y_d      = ctr_y_q;
    ctr_z_d      = ctr_z_q;
    vol_ok_d     = vol_ok_q;
    push_o       = 1'b0;
    cmd_o.kind   = CMD_CLEAR;
    cmd_o.slot   = entity_slot_i;
    cmd_o.vol_ok = vol_ok_q;
    if (accept) begin
      unique case (op_i)
        OP_CENTER: begin
          ctr_x_d    = pos_x_i;
          ctr_y_d    = pos_y_i;
          ctr_z_d    = pos_z_i;
          vol_ok_d   = node_valid_i;
          push_o     = 1'b1;
          cmd_o.kind = CMD_CLEAR;
        end
        OP_SAMPLE: begin
          push_o     = counts && hit;
          cmd_o.kind = CMD_SET;
        end
        OP_TICK: begin
          push_o     = 1'b1;
          cmd_o.kind = CMD_TICK;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctr_x_q  <= '0;
      ctr_y_q  <= '0;
      ctr_z_q  <= '0;
      vol_ok_q <= 1'b0;
    end else begin
      ctr_x_q  <= ctr_x_d;
      ctr_y_q  <= ctr_y_d;
      ctr_z_q  <= ctr_z_d;
      vol_ok_q <= vol_ok_d;
    end
  end

endmodule

@@ rtl/aerl_back.sv @@
module aerl_back #(
  parameter int Slots = aerl_pkg::DefaultSlots
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       queue_empty_i,
  input  aerl_pkg::cmd_t             cmd_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       event_kind_o,
  output logic [aerl_pkg::SlotW-1:0] event_slot_o,
  output logic                       last_event_o
);
  import aerl_pkg::*;

  back_state_e      state_q, state_d;
  logic [Slots-1:0] now_q, now_d;
  logic [Slots-1:0] prev_q, prev_d;
  logic [Slots-1:0] enter_q, enter_d;
  logic [Slots-1:0] leave_q, leave_d;
  logic [Slots-1:0] pick_e, pick_l;
  logic             out_valid_q, out_valid_d;
  logic             kind_q, kind_d;
  logic [SlotW-1:0] slot_q, slot_d;
  logic             last_q, last_d;
  logic             out_free;

  // index of a one-hot vector
  function automatic logic [SlotW-1:0] onehot_idx(logic [Slots-1:0] v);
    logic [SlotW-1:0] idx;
    idx = '0;
    for (int i = 0; i < Slots; i++) begin
      if (v[i]) begin
        idx = idx | SlotW'(i);
      end
    end
    return idx;
  endfunction

  assign pick_e   = enter_q & (~enter_q + Slots'(1));
  assign pick_l   = leave_q & (~leave_q + Slots'(1));
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    now_d       = now_q;
    prev_d      = prev_q;
    enter_d     = enter_q;
    leave_d     = leave_q;
    pop_o       = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    kind_d      = kind_q;
    slot_d      = slot_q;
    last_d      = last_q;
    unique case (state_q)
      BK_IDLE: begin
        if (!queue_empty_i) begin
          pop_o = 1'b1;
          unique case (cmd_i.kind)
            CMD_CLEAR: now_d = '0;
            CMD_SET: begin
              for (int i = 0; i < Slots; i++) begin
                if (int'(cmd_i.slot) == i) begin
                  now_d[i] = 1'b1;
                end
              end
            end
            CMD_TICK: begin
              now_d = '0;
              if (cmd_i.vol_ok) begin
                prev_d  = now_q;
                enter_d = now_q & ~prev_q;
                leave_d = prev_q & ~now_q;
                if ((now_q ^ prev_q) != '0) begin
                  state_d = BK_EMIT;
                end
              end
            end
            default: ;
          endcase
        end
      end
      BK_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          // enters drain first, lowest slot first, then leaves
          if (enter_q != '0) begin
            kind_d  = EV_ENTER;
            slot_d  = onehot_idx(pick_e);
            enter_d = enter_q & ~pick_e;
            last_d  = ((enter_q & ~pick_e) == '0) && (leave_q == '0);
          end else begin
            kind_d  = EV_LEAVE;
            slot_d  = onehot_idx(pick_l);
            leave_d = leave_q & ~pick_l;
            last_d  = ((leave_q & ~pick_l) == '0);
          end
          if (last_d) begin
            state_d = BK_IDLE;
          end
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      now_q       <= '0;
      prev_q      <= '0;
      enter_q     <= '0;
      leave_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      now_q       <= now_d;
      prev_q      <= prev_d;
      enter_q     <= enter_d;
      leave_q     <= leave_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    slot_q <= slot_d;
    last_q <= last_d;
  end

  assign out_valid_o  = out_valid_q;
  assign event_kind_o = kind_q;
  assign event_slot_o = slot_q;
  assign last_event_o = last_q;

endmodule

@@ rtl/aabb_region_enter_leave_detector.sv @@
// Enter/leave detector for one axis-aligned trigger box. Per tick feed a center item, then
// entity samples in ascending slot order, then an end-of-tick item. The front end takes one
// item per cycle while the queue is not full and tests the sample against the box in that
// cycle; center items, matching samples and tick markers go through a four-entry command
// queue to the back end, which keeps the current and previous inside sets. An end-of-tick
// item emits its events one at a time (enters in ascending slot order, then leaves),
// paced by the single output register, which out_stall_i can hold; the queue keeps taking
// items during that time until it fills. Configuration writes take effect at the next edge.
`include "aabb_region_enter_leave_detector_defines.svh"

module aabb_region_enter_leave_detector #(
  parameter int Slots = aerl_pkg::DefaultSlots
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [aerl_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [aerl_pkg::HalfW-1:0]          cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [1:0]                          op_i,
  input  logic                                node_valid_i,
  input  logic [aerl_pkg::SlotW-1:0]          entity_slot_i,
  input  logic [aerl_pkg::NameW-1:0]          name_id_i,
  input  logic signed [aerl_pkg::PosW-1:0]    pos_x_i,
  input  logic signed [aerl_pkg::PosW-1:0]    pos_y_i,
  input  logic signed [aerl_pkg::PosW-1:0]    pos_z_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                event_kind_o,
  output logic [aerl_pkg::SlotW-1:0]          event_slot_o,
  output logic                                last_event_o
);
  import aerl_pkg::*;

  cfg_t cfg_q, cfg_d;
  cmd_t push_cmd, pop_cmd;
  logic push, pop, q_full, q_empty;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_HALF_X: cfg_d.half_x    = cfg_data_i;
        REG_HALF_Y: cfg_d.half_y    = cfg_data_i;
        REG_HALF_Z: cfg_d.half_z    = cfg_data_i;
        REG_FILTER: cfg_d.filter_en = cfg_data_i[0];
        REG_TARGET: cfg_d.target_id = cfg_data_i[NameW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign in_stall_o = q_full;

  aerl_front #(
    .Slots(Slots)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .queue_full_i (q_full),
    .op_i         (op_i),
    .node_valid_i (node_valid_i),
    .entity_slot_i(entity_slot_i),
    .name_id_i    (name_id_i),
    .pos_x_i      (pos_x_i),
    .pos_y_i      (pos_y_i),
    .pos_z_i      (pos_z_i),
    .push_o       (push),
    .cmd_o        (push_cmd)
  );

  aerl_fifo #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_cmd),
    .pop_i      (pop),
    .pop_data_o (pop_cmd),
    .full_o     (q_full),
    .empty_o    (q_empty)
  );

  aerl_back #(
    .Slots(Slots)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .queue_empty_i(q_empty),
    .cmd_i        (pop_cmd),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .event_kind_o (event_kind_o),
    .event_slot_o (event_slot_o),
    .last_event_o (last_event_o)
  );

  `AERL_ASSERT_NOW(a_queue_flags, q_full, !q_empty)
  `AERL_ASSERT_NOW(a_pop_nonempty, pop, !q_empty)
  `AERL_ASSERT_NOW(a_slot_range, out_valid_o, int'(event_slot_o) < Slots)
  `AERL_ASSERT_NEXT(a_burst_continues, out_valid_o && !out_stall_i && !last_event_o, out_valid_o)

endmodule
